>>> rtl/vector_distance_l2_cosine_assert.svh
// Assertion macros shared by the vector distance RTL.
`ifndef VECTOR_DISTANCE_L2_COSINE_ASSERT_SVH
`define VECTOR_DISTANCE_L2_COSINE_ASSERT_SVH

// cond must hold on every clock outside reset
`define VDLC_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// ante implies cons on the same clock
`define VDLC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// ante implies cons on the following clock
`define VDLC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/vdlc_pkg.sv
// Types and constants for the vector distance block.
package vdlc_pkg;

    localparam int ELEM_W     = 16;  // element field width on the bus
    localparam int SQ_W       = 45;  // squared-difference sum, up to 8192 pairs
    localparam int DOT_W      = 44;  // signed dot product sum
    localparam int NRM_W      = 43;  // squared norm sum
    localparam int MAG_W      = DOT_W - 1;
    localparam int SQRT_W     = 46;  // root unit operand, even width
    localparam int ROOT_W     = SQRT_W / 2;
    localparam int NRT_W      = 22;  // root of a norm sum
    localparam int DEN_W      = 2 * NRT_W;
    localparam int FRAC_BITS  = 15;
    localparam int Q_BITS     = FRAC_BITS + 2; // quotient stays below 2^17
    localparam int QCNT_W     = $clog2(Q_BITS);
    localparam int RES_W      = 23;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 24;
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

    localparam logic METRIC_L2  = 1'b0;
    localparam logic METRIC_COS = 1'b1;

    localparam logic signed [ELEM_W-1:0] Q15_MAX = 16'sh7FFF;
    localparam logic signed [ELEM_W-1:0] Q15_MIN = 16'sh8000;

    typedef struct packed {
        logic                    metric;
        logic [SQ_W-1:0]         sq;
        logic signed [DOT_W-1:0] dot;
        logic [NRM_W-1:0]        nu;
        logic [NRM_W-1:0]        nv;
    } t_job;

    typedef enum logic [2:0] {
        S_IDLE,
        S_L2,
        S_RU,
        S_RV,
        S_MUL,
        S_DIV,
        S_SAT,
        S_DONE
    } t_back_state;

endpackage

>>> rtl/vdlc_fifo.sv
// Small job queue between the accumulator front and the finishing back end.
module vdlc_fifo
    import vdlc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  t_job                  i_job,
    input  logic                  i_pop,
    output t_job                  o_head,
    output logic                  o_empty,
    output logic [FIFO_CNT_W-1:0] o_cnt
);

    t_job                  r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wp;
    logic [FIFO_PTR_W-1:0] r_rp;
    logic [FIFO_CNT_W-1:0] r_cnt;

    function automatic logic [FIFO_PTR_W-1:0] ptr_inc(input logic [FIFO_PTR_W-1:0] p);
        if (p == FIFO_PTR_W'(FIFO_DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= ptr_inc(r_wp);
            end
            if (i_pop) begin
                r_rp <= ptr_inc(r_rp);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    assign o_head  = r_mem[r_rp];
    assign o_empty = (r_cnt == '0);
    assign o_cnt   = r_cnt;

endmodule

>>> rtl/vdlc_front.sv
// Front end: takes element pairs, forms products, accumulates, queues finished sums.
module vdlc_front
    import vdlc_pkg::*;
#(
    parameter int MAX_DIMS  = 1024,
    parameter int ELEM_BITS = 16
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_metric,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // u_elem[15:0], v_elem[31:16]
    input  logic                  s_axis_tlast,   // last
    input  logic [FIFO_CNT_W-1:0] i_fifo_cnt,
    output logic                  o_push,
    output t_job                  o_job
);

    localparam int SH    = ELEM_W - ELEM_BITS;
    localparam int CNT_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

    logic signed [ELEM_W-1:0] w_u;
    logic signed [ELEM_W-1:0] w_v;
    logic signed [ELEM_W:0]   w_d;
    logic signed [2*ELEM_W+1:0] w_dd;
    logic signed [2*ELEM_W-1:0] w_uv;
    logic signed [2*ELEM_W-1:0] w_uu;
    logic signed [2*ELEM_W-1:0] w_vv;
    logic                     w_acc;
    logic                     w_end;
    logic [FIFO_CNT_W:0]      w_used;

    logic [CNT_W-1:0]         r_ecnt;
    logic                     r_p_vld;
    logic                     r_p_end;
    logic [2*ELEM_W:0]        r_p_sq;
    logic signed [2*ELEM_W-1:0] r_p_uv;
    logic [2*ELEM_W-1:0]      r_p_uu;
    logic [2*ELEM_W-1:0]      r_p_vv;

    logic [SQ_W-1:0]          r_acc_sq;
    logic signed [DOT_W-1:0]  r_acc_dot;
    logic [NRM_W-1:0]         r_acc_nu;
    logic [NRM_W-1:0]         r_acc_nv;
    logic [SQ_W-1:0]          n_acc_sq;
    logic signed [DOT_W-1:0]  n_acc_dot;
    logic [NRM_W-1:0]         n_acc_nu;
    logic [NRM_W-1:0]         n_acc_nv;

    // sign-extend from bit ELEM_BITS-1
    assign w_u  = $signed(s_axis_tdata[ELEM_W-1:0] << SH) >>> SH;
    assign w_v  = $signed(s_axis_tdata[2*ELEM_W-1:ELEM_W] << SH) >>> SH;
    assign w_d  = (ELEM_W+1)'(w_u) - (ELEM_W+1)'(w_v);
    assign w_dd = (2*ELEM_W+2)'(w_d) * (2*ELEM_W+2)'(w_d);
    assign w_uv = (2*ELEM_W)'(w_u) * (2*ELEM_W)'(w_v);
    assign w_uu = (2*ELEM_W)'(w_u) * (2*ELEM_W)'(w_u);
    assign w_vv = (2*ELEM_W)'(w_v) * (2*ELEM_W)'(w_v);

    // room for every vector already ended but not yet queued
    assign w_used        = (FIFO_CNT_W+1)'(i_fifo_cnt) + (FIFO_CNT_W+1)'(r_p_vld && r_p_end);
    assign s_axis_tready = (w_used < (FIFO_CNT_W+1)'(FIFO_DEPTH));
    assign w_acc         = s_axis_tvalid && s_axis_tready;
    assign w_end         = s_axis_tlast || (r_ecnt == CNT_W'(MAX_DIMS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ecnt  <= '0;
            r_p_vld <= 1'b0;
            r_p_end <= 1'b0;
        end else begin
            r_p_vld <= w_acc;
            if (w_acc) begin
                r_p_end <= w_end;
                r_ecnt  <= w_end ? '0 : r_ecnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_p_sq <= w_dd[2*ELEM_W:0];
            r_p_uv <= w_uv;
            r_p_uu <= w_uu;
            r_p_vv <= w_vv;
        end
    end

    always_comb begin
        n_acc_sq  = r_acc_sq + SQ_W'(r_p_sq);
        n_acc_dot = r_acc_dot + DOT_W'(r_p_uv);
        n_acc_nu  = r_acc_nu + NRM_W'(r_p_uu);
        n_acc_nv  = r_acc_nv + NRM_W'(r_p_vv);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_sq  <= '0;
            r_acc_dot <= '0;
            r_acc_nu  <= '0;
            r_acc_nv  <= '0;
        end else if (r_p_vld) begin
            if (r_p_end) begin
                r_acc_sq  <= '0;
                r_acc_dot <= '0;
                r_acc_nu  <= '0;
                r_acc_nv  <= '0;
            end else begin
                r_acc_sq  <= n_acc_sq;
                r_acc_dot <= n_acc_dot;
                r_acc_nu  <= n_acc_nu;
                r_acc_nv  <= n_acc_nv;
            end
        end
    end

    always_comb begin
        o_job.metric = i_metric;
        o_job.sq     = n_acc_sq;
        o_job.dot    = n_acc_dot;
        o_job.nu     = n_acc_nu;
        o_job.nv     = n_acc_nv;
    end

    assign o_push = r_p_vld && r_p_end;

endmodule

>>> rtl/vdlc_isqrt.sv
// Integer square root, one result bit per cycle.
module vdlc_isqrt
    import vdlc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SQRT_W-1:0] i_val,
    output logic              o_done,
    output logic [ROOT_W-1:0] o_root
);

    logic              r_busy;
    logic              r_done;
    logic [SQRT_W-1:0] r_n;
    logic [SQRT_W-1:0] r_root;
    logic [SQRT_W-1:0] r_bit;
    logic [SQRT_W-1:0] w_trial;
    logic              w_ge;

    assign w_trial = r_root + r_bit;
    assign w_ge    = (r_n >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit[0]) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n    <= i_val;
            r_root <= '0;
            r_bit  <= SQRT_W'(1) << (SQRT_W - 2);
        end else if (r_busy) begin
            if (w_ge) begin
                r_n    <= r_n - w_trial;
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_root[ROOT_W-1:0];

endmodule

>>> rtl/vdlc_back.sv
// Back end: square roots, cosine divide and saturation, result register.
module vdlc_back
    import vdlc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_empty,
    input  t_job                  i_head,
    output logic                  o_pop,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata   // result[22:0], zero pad
);

    t_back_state              r_state;
    t_back_state              n_state;
    t_job                     r_job;
    logic [NRT_W-1:0]         r_ru;
    logic [NRT_W-1:0]         r_rv;
    logic [DEN_W-1:0]         r_den;
    logic [DEN_W-1:0]         r_rem;
    logic [Q_BITS-1:0]        r_low;
    logic [Q_BITS-1:0]        r_quo;
    logic [QCNT_W-1:0]        r_dcnt;
    logic                     r_neg;
    logic [RES_W-1:0]         r_res;
    logic                     r_m_valid;
    logic [RES_W-1:0]         r_m_data;

    logic                     w_sq_start;
    logic [SQRT_W-1:0]        w_sq_val;
    logic                     w_sq_done;
    logic [ROOT_W-1:0]        w_root;
    logic                     w_out_free;
    logic [DOT_W-1:0]         w_abs;
    logic [MAG_W-1:0]         w_mag;
    logic [DEN_W:0]           w_trial;
    logic                     w_ge;
    logic signed [ELEM_W-1:0] w_sat;

    vdlc_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_val   (w_sq_val),
        .o_done  (w_sq_done),
        .o_root  (w_root)
    );

    assign w_out_free = !r_m_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_pop      = 1'b0;
        w_sq_start = 1'b0;
        w_sq_val   = SQRT_W'(i_head.sq);
        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    if (i_head.metric == METRIC_L2) begin
                        w_sq_start = 1'b1;
                        n_state    = S_L2;
                    end else if (i_head.nu == '0 || i_head.nv == '0) begin
                        n_state = S_DONE;
                    end else begin
                        w_sq_start = 1'b1;
                        w_sq_val   = SQRT_W'(i_head.nu);
                        n_state    = S_RU;
                    end
                end
            end
            S_L2: begin
                if (w_sq_done) begin
                    n_state = S_DONE;
                end
            end
            S_RU: begin
                if (w_sq_done) begin
                    w_sq_start = 1'b1;
                    w_sq_val   = SQRT_W'(r_job.nv);
                    n_state    = S_RV;
                end
            end
            S_RV: begin
                if (w_sq_done) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (r_dcnt == QCNT_W'(Q_BITS - 1)) begin
                    n_state = S_SAT;
                end
            end
            S_SAT: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // magnitude of the dot product and one restoring divide step
    always_comb begin
        w_abs   = r_job.dot[DOT_W-1] ? DOT_W'(-r_job.dot) : DOT_W'(r_job.dot);
        w_mag   = w_abs[MAG_W-1:0];
        w_trial = {r_rem, r_low[Q_BITS-1]};
        w_ge    = (w_trial >= {1'b0, r_den});
    end

    // truncated quotient, then clamp to Q1.15
    always_comb begin
        if (!r_neg) begin
            w_sat = (r_quo > Q_BITS'(Q15_MAX)) ? Q15_MAX : $signed(r_quo[ELEM_W-1:0]);
        end else begin
            w_sat = (r_quo[Q_BITS-1:ELEM_W-1] != '0) ? Q15_MIN
                                                     : $signed(-r_quo[ELEM_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    r_job <= i_head;
                    r_res <= '0;
                end
            end
            S_L2: begin
                if (w_sq_done) begin
                    r_res <= RES_W'(w_root);
                end
            end
            S_RU: begin
                if (w_sq_done) begin
                    r_ru <= w_root[NRT_W-1:0];
                end
            end
            S_RV: begin
                if (w_sq_done) begin
                    r_rv <= w_root[NRT_W-1:0];
                end
            end
            S_MUL: begin
                r_den  <= DEN_W'(r_ru) * DEN_W'(r_rv);
                r_rem  <= DEN_W'(w_mag >> 2);
                r_low  <= {w_mag[1:0], {FRAC_BITS{1'b0}}};
                r_quo  <= '0;
                r_dcnt <= '0;
                r_neg  <= r_job.dot[DOT_W-1];
            end
            S_DIV: begin
                r_rem  <= w_ge ? DEN_W'(w_trial - {1'b0, r_den}) : w_trial[DEN_W-1:0];
                r_quo  <= {r_quo[Q_BITS-2:0], w_ge};
                r_low  <= r_low << 1;
                r_dcnt <= r_dcnt + 1'b1;
            end
            S_SAT: begin
                r_res <= RES_W'(w_sat);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (r_state == S_DONE && w_out_free) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_free) begin
            r_m_data <= r_res;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = OUT_DATA_W'(r_m_data);

endmodule

>>> rtl/vector_distance_l2_cosine.sv
// Top level of the Euclidean / cosine vector distance block.
// Two vectors stream in as element pairs, one beat per pair, tlast on the final pair.
// The front end takes one beat every cycle while s_axis_tready is high: it
// registers the four products (squared difference, u*v, u*u, v*v) and adds
// them into 45/44/43-bit accumulators in the following cycle. The pair marked
// tlast, or the MAX_DIMS-th pair since the previous result, closes the vector; its
// sums go into a two-entry queue and the accumulators restart at zero. The back end
// takes one queued vector at a time through a shared bit-per-cycle square root unit:
//   L2 (metric 0):     floor(sqrt(sq_diff)).
//   cosine (metric 1): dot * 2^15 / (isqrt(norm_u) * isqrt(norm_v)), truncated
//                      toward zero and clamped to Q1.15; 0 when a norm is zero.
//                      Two roots, one multiply and a 17-step restoring divide.
// The back end time per vector sets the pace: vectors with at least as many pairs
// as it takes cycles run at one pair per cycle; shorter vectors back-pressure
// s_axis_tready once two finished vectors are queued or about to be. The result
// sits in an output register, so the front keeps accumulating while it waits.
// The metric register is written on the cfg channel (always ready) and should
// only change while no vector is in flight; it is captured with each vector.
// ELEM_BITS narrows the elements: only the low ELEM_BITS of each field are
// used, sign-extended.
`include "vector_distance_l2_cosine_assert.svh"

module vector_distance_l2_cosine
    import vdlc_pkg::*;
#(
    parameter int MAX_DIMS  = 1024,
    parameter int ELEM_BITS = 16
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // config: metric
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic                  i_cfg_data,     // metric
    // element pairs
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // u_elem[15:0], v_elem[31:16]
    input  logic                  s_axis_tlast,   // last
    // results
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata    // result[22:0], bit 23 zero
);

    logic                  r_metric;
    logic                  w_push;
    logic                  w_pop;
    logic                  w_empty;
    logic [FIFO_CNT_W-1:0] w_fifo_cnt;
    t_job                  w_job_in;
    t_job                  w_head;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_metric <= METRIC_L2;
        end else if (i_cfg_valid) begin
            r_metric <= i_cfg_data;
        end
    end

    vdlc_front #(
        .MAX_DIMS  (MAX_DIMS),
        .ELEM_BITS (ELEM_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_metric      (r_metric),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .i_fifo_cnt    (w_fifo_cnt),
        .o_push        (w_push),
        .o_job         (w_job_in)
    );

    // finished sums wait here for the back end
    vdlc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_empty (w_empty),
        .o_cnt   (w_fifo_cnt)
    );

    vdlc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (w_empty),
        .i_head        (w_head),
        .o_pop         (w_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // front credit check must keep the queue from overflowing
    `VDLC_ASSERT_IMPL(a_push_room, i_clk, i_rst_n, w_push && !w_pop, w_fifo_cnt < FIFO_CNT_W'(FIFO_DEPTH), "job pushed into full queue")
    `VDLC_ASSERT_IMPL(a_pop_data, i_clk, i_rst_n, w_pop, w_fifo_cnt != '0, "job popped from empty queue")
    `VDLC_ASSERT_NEXT(a_push_held, i_clk, i_rst_n, w_push && !w_pop, !w_empty, "pushed job lost")
    `VDLC_ASSERT_ALWAYS(a_cnt_bound, i_clk, i_rst_n, w_fifo_cnt <= FIFO_CNT_W'(FIFO_DEPTH), "queue count out of range")

endmodule
